// ----- design/ces_pkg.sv -----
// ----------------------------------------------------------------------------
// ces_pkg
// shared types and constants of the call edge stack profiler
// ----------------------------------------------------------------------------
package ces_pkg;

  localparam int STACK_DEPTH   = 64;
  localparam int TABLE_ENTRIES = 256;

  localparam int STACK_AW = $clog2(STACK_DEPTH);
  localparam int SP_W     = $clog2(STACK_DEPTH + 1);
  localparam int TBL_AW   = $clog2(TABLE_ENTRIES);
  localparam int TBL_W    = $clog2(TABLE_ENTRIES + 1);

  typedef enum logic [2:0] {
    REQ_CALL  = 3'd0,
    REQ_RET   = 3'd1,
    REQ_SUB   = 3'd2,
    REQ_FRAME = 3'd3,
    REQ_ADD   = 3'd4
  } req_kind_t;

  typedef enum logic [2:0] {
    ST_CREATED     = 3'd0,
    ST_UPDATED     = 3'd1,
    ST_NO_EDGE     = 3'd2,
    ST_STACK_EMPTY = 3'd3,
    ST_RET_MISMATCH = 3'd4,
    ST_TABLE_FULL  = 3'd5,
    ST_STACK_FULL  = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TOP,
    S_SEARCH,
    S_APPEND,
    S_UPDATE,
    S_DONE
  } state_t;

  // one shadow stack frame, also the search key of an edge
  typedef struct packed {
    logic [31:0] caller;
    logic [31:0] callee;
    logic [31:0] ret_addr;
  } frame_t;

  typedef struct packed {
    frame_t             key;
    logic [31:0]        hits;
    logic signed [31:0] frame;
    logic signed [31:0] extra;
    logic signed [31:0] peak;
  } edge_t;

  typedef struct packed {
    status_t            status;
    logic [7:0]         edge_index;
    logic [31:0]        edge_caller;
    logic [31:0]        edge_callee;
    logic [31:0]        hit_count;
    logic signed [31:0] frame_size;
    logic signed [31:0] extra_size;
    logic signed [31:0] peak_value;
  } res_t;

  localparam int FRAME_W = $bits(frame_t);
  localparam int EDGE_W  = $bits(edge_t);

endpackage

// ----- design/ces_req_if.sv -----
// ----------------------------------------------------------------------------
// ces_req_if
// request channel: trace event with valid/ready handshake
// ----------------------------------------------------------------------------
interface ces_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         req_type;
  logic [31:0]        callee_addr;
  logic [31:0]        return_addr;
  logic signed [31:0] amount;

  modport source (output valid, req_type, callee_addr, return_addr, amount, input ready);
  modport sink   (input valid, req_type, callee_addr, return_addr, amount, output ready);
endinterface

// ----- design/ces_res_if.sv -----
// ----------------------------------------------------------------------------
// ces_res_if
// result channel: touched edge report with valid/ready handshake
// ----------------------------------------------------------------------------
interface ces_res_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic [7:0]         edge_index;
  logic [31:0]        edge_caller;
  logic [31:0]        edge_callee;
  logic [31:0]        hit_count;
  logic signed [31:0] frame_size;
  logic signed [31:0] extra_size;
  logic signed [31:0] peak_value;

  modport source (output valid, status, edge_index, edge_caller, edge_callee, hit_count,
                  frame_size, extra_size, peak_value, input ready);
  modport sink   (input valid, status, edge_index, edge_caller, edge_callee, hit_count,
                  frame_size, extra_size, peak_value, output ready);
endinterface

// ----- design/ces_ram.sv -----
// ----------------------------------------------------------------------------
// ces_ram
// simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module ces_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/call_edge_stack_profiler.sv -----
// ----------------------------------------------------------------------------
// call_edge_stack_profiler
// shadow call stack plus call edge table, one report per trace event
// ----------------------------------------------------------------------------
// One request is taken at a time. The edge table sits in a ram with a single
// read port, and the search compares one stored edge per cycle, in append
// order, through one shared key comparator. A search ends when it finds its
// edge, which is then updated, or when it has passed every stored edge; a call
// that finds nothing then appends. A call on an empty stack skips the search,
// and any request that fails early (stack full, stack empty, return mismatch,
// unknown kind) goes straight to its report. The report is held in an output
// register, so a new request is accepted while the previous report waits to be
// taken; only while that register is still full at the end of a request does
// the block stall, and it stays stalled for as long as the register is full.
// Stack and table contents need no clearing after reset: only entries below the
// stack level and the edge count are ever used.
module call_edge_stack_profiler (
  input logic clk,
  input logic rst,
  ces_req_if.sink   req,
  ces_res_if.source res
);
  import ces_pkg::*;

  state_t state, state_next;

  // latched request
  logic [2:0]         op_type;
  logic [31:0]        op_callee;
  logic [31:0]        op_ret;
  logic signed [31:0] op_amount;

  logic [SP_W-1:0]  stack_level, stack_level_next;
  logic [TBL_W-1:0] edges_used, edges_used_next;
  frame_t           last, last_next;
  frame_t           key, key_next;

  // search pointer and compare slot
  logic [TBL_W-1:0]  scan, scan_next;
  logic              cmp_valid, cmp_valid_next;
  logic [TBL_AW-1:0] cmp_idx, cmp_idx_next;

  res_t res_pend, res_pend_next;
  res_t out_reg;
  logic out_valid;

  // ram ports
  logic                stk_we, stk_re;
  logic [STACK_AW-1:0] stk_waddr, stk_raddr;
  frame_t              stk_wdata;
  logic [FRAME_W-1:0]  stk_rdata;
  frame_t              stk_top;

  logic              tbl_we, tbl_re;
  logic [TBL_AW-1:0] tbl_waddr, tbl_raddr;
  edge_t             tbl_wdata;
  logic [EDGE_W-1:0] tbl_rdata;
  edge_t             tbl_entry;

  logic   accept;
  logic   out_free;
  logic   stack_empty;
  logic   match;
  frame_t new_frame;
  edge_t  upd;

  assign accept      = req.valid && req.ready;
  assign out_free    = !out_valid || res.ready;
  assign stack_empty = (stack_level == '0);
  assign stk_top     = stk_rdata;
  assign tbl_entry   = tbl_rdata;

  // the shared key comparator
  assign match = cmp_valid && (tbl_entry.key == key);

  ces_ram #(.WIDTH(FRAME_W), .DEPTH(STACK_DEPTH)) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .re    (stk_re),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  ces_ram #(.WIDTH(EDGE_W), .DEPTH(TABLE_ENTRIES)) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .re    (tbl_re),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  function automatic res_t res_none(status_t st);
    res_t r;
    r        = '0;
    r.status = st;
    return r;
  endfunction

  function automatic res_t res_edge(status_t st, logic [TBL_AW-1:0] idx, edge_t e);
    res_t r;
    r.status      = st;
    r.edge_index  = 8'(idx);
    r.edge_caller = e.key.caller;
    r.edge_callee = e.key.callee;
    r.hit_count   = e.hits;
    r.frame_size  = e.frame;
    r.extra_size  = e.extra;
    r.peak_value  = e.peak;
    return r;
  endfunction

  // frame pushed by a call: caller is the callee of the top frame, or zero on an empty stack
  always_comb begin
    new_frame.caller   = stack_empty ? 32'd0 : stk_top.callee;
    new_frame.callee   = op_callee;
    new_frame.ret_addr = op_ret;
  end

  // update of a found edge, by request kind
  always_comb begin
    upd = tbl_entry;
    case (op_type)
      REQ_CALL: begin
        upd.hits = tbl_entry.hits + 32'd1;
      end
      REQ_RET: begin
        if (tbl_entry.peak < op_amount) upd.peak = op_amount;
      end
      REQ_SUB, REQ_FRAME: begin
        if (tbl_entry.frame < op_amount) upd.frame = tbl_entry.frame + op_amount;
      end
      REQ_ADD: begin
        if (tbl_entry.extra < op_amount) upd.extra = op_amount;
      end
      default: begin
        upd = tbl_entry;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_next       = state;
    stack_level_next = stack_level;
    edges_used_next  = edges_used;
    last_next        = last;
    key_next         = key;
    scan_next        = scan;
    cmp_valid_next   = cmp_valid;
    cmp_idx_next     = cmp_idx;
    res_pend_next    = res_pend;

    stk_we    = 1'b0;
    stk_waddr = STACK_AW'(stack_level);
    stk_wdata = new_frame;
    stk_re    = 1'b0;
    stk_raddr = STACK_AW'(stack_level - 1'b1);

    tbl_we    = 1'b0;
    tbl_waddr = cmp_idx;
    tbl_wdata = upd;
    tbl_re    = 1'b0;
    tbl_raddr = scan[TBL_AW-1:0];

    case (state)
      S_IDLE: begin
        // fetch the top frame while the request is latched
        if (accept) begin
          stk_re     = 1'b1;
          state_next = S_TOP;
        end
      end

      S_TOP: begin
        scan_next      = '0;
        cmp_valid_next = 1'b0;
        case (op_type)
          REQ_CALL: begin
            if (stack_level == SP_W'(STACK_DEPTH)) begin
              res_pend_next = res_none(ST_STACK_FULL);
              state_next    = S_DONE;
            end else begin
              key_next         = new_frame;
              stk_we           = 1'b1;
              stack_level_next = stack_level + 1'b1;
              // a call from an empty stack skips the search and appends a fresh edge if there is room
              state_next       = stack_empty ? S_APPEND : S_SEARCH;
            end
          end
          REQ_RET: begin
            if (stack_empty) begin
              res_pend_next = res_none(ST_STACK_EMPTY);
              state_next    = S_DONE;
            end else if (stk_top.ret_addr != op_ret) begin
              res_pend_next = res_none(ST_RET_MISMATCH);
              state_next    = S_DONE;
            end else begin
              key_next         = stk_top;
              last_next        = stk_top;
              stack_level_next = stack_level - 1'b1;
              state_next       = S_SEARCH;
            end
          end
          REQ_SUB, REQ_FRAME: begin
            if (stack_empty) begin
              res_pend_next = res_none(ST_STACK_EMPTY);
              state_next    = S_DONE;
            end else begin
              key_next   = stk_top;
              state_next = S_SEARCH;
            end
          end
          REQ_ADD: begin
            key_next   = last;
            state_next = S_SEARCH;
          end
          default: begin
            res_pend_next = res_none(ST_NO_EDGE);
            state_next    = S_DONE;
          end
        endcase
      end

      S_SEARCH: begin
        // read one entry per cycle, compare the one read the cycle before
        if (match) begin
          state_next = S_UPDATE;
        end else if (scan < edges_used) begin
          tbl_re         = 1'b1;
          cmp_idx_next   = scan[TBL_AW-1:0];
          cmp_valid_next = 1'b1;
          scan_next      = scan + 1'b1;
        end else if (op_type == REQ_CALL) begin
          state_next = S_APPEND;
        end else begin
          res_pend_next = res_none(ST_NO_EDGE);
          state_next    = S_DONE;
        end
      end

      S_APPEND: begin
        if (edges_used == TBL_W'(TABLE_ENTRIES)) begin
          res_pend_next = res_none(ST_TABLE_FULL);
        end else begin
          tbl_we          = 1'b1;
          tbl_waddr       = TBL_AW'(edges_used);
          tbl_wdata       = '0;
          tbl_wdata.key   = key;
          tbl_wdata.hits  = 32'd1;
          edges_used_next = edges_used + 1'b1;
          res_pend_next   = res_edge(ST_CREATED, TBL_AW'(edges_used), tbl_wdata);
        end
        state_next = S_DONE;
      end

      S_UPDATE: begin
        tbl_we        = 1'b1;
        res_pend_next = res_edge(ST_UPDATED, cmp_idx, upd);
        state_next    = S_DONE;
      end

      S_DONE: begin
        if (out_free) state_next = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      stack_level <= '0;
      edges_used  <= '0;
      last        <= '0;
      cmp_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      stack_level <= stack_level_next;
      edges_used  <= edges_used_next;
      last        <= last_next;
      cmp_valid   <= cmp_valid_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_type   <= req.req_type;
      op_callee <= req.callee_addr;
      op_ret    <= req.return_addr;
      op_amount <= req.amount;
    end
    key      <= key_next;
    scan     <= scan_next;
    cmp_idx  <= cmp_idx_next;
    res_pend <= res_pend_next;
  end

  // output register, loaded when the slot is free
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) out_reg <= res_pend;
  end

  assign req.ready       = (state == S_IDLE);
  assign res.valid       = out_valid;
  assign res.status      = out_reg.status;
  assign res.edge_index  = out_reg.edge_index;
  assign res.edge_caller = out_reg.edge_caller;
  assign res.edge_callee = out_reg.edge_callee;
  assign res.hit_count   = out_reg.hit_count;
  assign res.frame_size  = out_reg.frame_size;
  assign res.extra_size  = out_reg.extra_size;
  assign res.peak_value  = out_reg.peak_value;

  // stack and table never overflow
  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    stack_level <= SP_W'(STACK_DEPTH))
    else $error("stack level beyond depth");

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    edges_used <= TBL_W'(TABLE_ENTRIES))
    else $error("edge count beyond table size");

  // search never walks past the stored edges
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEARCH) |-> (scan <= edges_used))
    else $error("search pointer past edge count");

  // an append that has room grows the table by one
  a_append_grows: assert property (@(posedge clk) disable iff (rst)
    (state == S_APPEND && edges_used != TBL_W'(TABLE_ENTRIES))
      |=> (edges_used == $past(edges_used) + 1'b1))
    else $error("append did not count the new edge");

  // a hit only comes from a stored edge
  a_hit_stored: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEARCH && match) |-> (TBL_W'(cmp_idx) < edges_used))
    else $error("hit on an edge that was never stored");

endmodule
